### rtl/core/ihe_pkg.sv
// Package with the types and constants shared by the header extractor modules.
package ihe_pkg;

    localparam int COUNT_BITS_DEF = 11;

    localparam int ETH_HDR_LEN = 14;
    localparam int MAC_LEN = 6;
    localparam int IP_PROTO_OFS = 9;
    localparam int IP_ADDR_OFS = 12;
    localparam int IPV4_MIN_HDR = 20;
    localparam int ICMP_LEN = 8;
    localparam int FRAME_LEN_MAX = 2047;

    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0] PROTO_NUM_ICMP = 8'd1;
    localparam logic [3:0] IHL_MASK = 4'hf;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } ihe_item_t;

    typedef struct packed {
        logic [10:0] frame_len;
        logic [47:0] dst_mac;
        logic [47:0] src_mac;
        logic [15:0] ether_type;
        logic        is_icmp;
        logic [7:0]  msg_type;
        logic [7:0]  msg_code;
        logic [15:0] icmp_ident;
        logic [15:0] icmp_sequence;
        logic [31:0] ip_source;
        logic [31:0] ip_destination;
    } ihe_record_t;

endpackage

### rtl/core/eth_ipv4_icmp_header_extract.sv
// Top level of the Ethernet, IPv4 and ICMP header extractor.
//
//  channel  direction  handshake           payload
//  in       sink       in_valid/in_stall   data_byte, last_byte
//  out      source     out_valid/out_stall frame_len .. ip_destination
//
// One byte is accepted per cycle unless in_stall is high; a record passes the input register,
// the combinational capture logic and then the result register before it leaves.
// Reset clears the byte count and all captured fields.
// The input stalls only when a last byte waits for a stalled result register.
module eth_ipv4_icmp_header_extract
#(
    parameter int COUNT_BITS = ihe_pkg::COUNT_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [10:0] frame_len,
    output logic [47:0] dst_mac,
    output logic [47:0] src_mac,
    output logic [15:0] ether_type,
    output logic        is_icmp,
    output logic [7:0]  msg_type,
    output logic [7:0]  msg_code,
    output logic [15:0] icmp_ident,
    output logic [15:0] icmp_sequence,
    output logic [31:0] ip_source,
    output logic [31:0] ip_destination
);
    import ihe_pkg::*;

    ihe_item_t   item;
    ihe_record_t rec_next;
    ihe_record_t rec;
    logic        adv;
    logic        out_free;
    logic        rec_load;

    ihe_in_stage u_in_stage
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .out_free  (out_free),
        .in_stall  (in_stall),
        .adv       (adv),
        .item      (item)
    );

    ihe_capture #(
        .COUNT_BITS (COUNT_BITS)
    ) u_capture
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .item     (item),
        .rec_load (rec_load),
        .rec_next (rec_next)
    );

    ihe_out_stage u_out_stage
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .rec_load  (rec_load),
        .rec_next  (rec_next),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_free  (out_free),
        .rec       (rec)
    );

    assign frame_len = rec.frame_len;
    assign dst_mac = rec.dst_mac;
    assign src_mac = rec.src_mac;
    assign ether_type = rec.ether_type;
    assign is_icmp = rec.is_icmp;
    assign msg_type = rec.msg_type;
    assign msg_code = rec.msg_code;
    assign icmp_ident = rec.icmp_ident;
    assign icmp_sequence = rec.icmp_sequence;
    assign ip_source = rec.ip_source;
    assign ip_destination = rec.ip_destination;

`ifndef SYNTHESIS
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled while the result side is free");
`endif

endmodule

### rtl/core/ihe_in_stage.sv
// Input register that holds one frame byte until the capture logic takes it.
module ihe_in_stage
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [7:0]        data_byte,
    input  logic              last_byte,
    input  logic              out_free,
    output logic              in_stall,
    output logic              adv,
    output ihe_pkg::ihe_item_t item
);
    import ihe_pkg::*;

    logic      item_valid_reg;
    ihe_item_t item_reg;
    logic      load;

    // A byte that closes a frame moves on only when the result register has room.
    assign adv = item_valid_reg && (!item_reg.last_byte || out_free);
    assign in_stall = item_valid_reg && !adv;
    assign load = in_valid && !in_stall;
    assign item = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            item_valid_reg <= 1'b1;
        end
        else if (adv)
        begin
            item_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= '{data_byte: data_byte, last_byte: last_byte};
        end
    end

endmodule

### rtl/core/ihe_capture.sv
// Frame state registers, per-byte field capture and result record assembly.
module ihe_capture
#(
    parameter int COUNT_BITS = ihe_pkg::COUNT_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  ihe_pkg::ihe_item_t  item,
    output logic                rec_load,
    output ihe_pkg::ihe_record_t rec_next
);
    import ihe_pkg::*;

    localparam int EXT_W = COUNT_BITS + 8;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    logic [COUNT_BITS-1:0] byte_count_reg;
    logic [47:0]           dst_mac_reg;
    logic [47:0]           src_mac_reg;
    logic [15:0]           ether_type_reg;
    logic [5:0]            ip_header_len_reg;
    logic [7:0]            ip_protocol_reg;
    logic [63:0]           ip_addresses_reg;
    logic [63:0]           icmp_bytes_reg;

    logic [COUNT_BITS-1:0] byte_count_next;
    logic [47:0]           dst_mac_next;
    logic [47:0]           src_mac_next;
    logic [15:0]           ether_type_next;
    logic [5:0]            ip_header_len_next;
    logic [7:0]            ip_protocol_next;
    logic [63:0]           ip_addresses_next;
    logic [63:0]           icmp_bytes_next;

    logic [EXT_W-1:0]      pos_ext;
    logic [EXT_W-1:0]      len_ext;
    logic [EXT_W-1:0]      icmp_start;
    logic                  capture_en;
    logic                  icmp_match;
    logic [7:0]            b;

    assign rec_load = adv && item.last_byte;

    always_comb
    begin
        b = item.data_byte;
        pos_ext = EXT_W'(byte_count_reg);
        capture_en = byte_count_reg != CNT_MAX;

        // The first byte of a frame starts from cleared fields.
        if (byte_count_reg == '0)
        begin
            dst_mac_next = '0;
            src_mac_next = '0;
            ether_type_next = '0;
            ip_header_len_next = '0;
            ip_protocol_next = '0;
            ip_addresses_next = '0;
            icmp_bytes_next = '0;
        end
        else
        begin
            dst_mac_next = dst_mac_reg;
            src_mac_next = src_mac_reg;
            ether_type_next = ether_type_reg;
            ip_header_len_next = ip_header_len_reg;
            ip_protocol_next = ip_protocol_reg;
            ip_addresses_next = ip_addresses_reg;
            icmp_bytes_next = icmp_bytes_reg;
        end

        if (capture_en)
        begin
            if (pos_ext < EXT_W'(MAC_LEN))
            begin
                dst_mac_next = {dst_mac_next[39:0], b};
            end
            else if (pos_ext < EXT_W'(2 * MAC_LEN))
            begin
                src_mac_next = {src_mac_next[39:0], b};
            end
            else if (pos_ext < EXT_W'(ETH_HDR_LEN))
            begin
                ether_type_next = {ether_type_next[7:0], b};
            end
            if (pos_ext == EXT_W'(ETH_HDR_LEN))
            begin
                ip_header_len_next = {b[3:0] & IHL_MASK, 2'b00};
            end
            if (pos_ext == EXT_W'(ETH_HDR_LEN + IP_PROTO_OFS))
            begin
                ip_protocol_next = b;
            end
            if (pos_ext >= EXT_W'(ETH_HDR_LEN + IP_ADDR_OFS)
                && pos_ext < EXT_W'(ETH_HDR_LEN + IPV4_MIN_HDR))
            begin
                ip_addresses_next = {ip_addresses_next[55:0], b};
            end
        end

        // The ICMP window follows the header length, including one just taken.
        icmp_start = EXT_W'(ETH_HDR_LEN) + EXT_W'(ip_header_len_next);
        if (capture_en && pos_ext >= icmp_start
            && pos_ext < icmp_start + EXT_W'(ICMP_LEN))
        begin
            icmp_bytes_next = {icmp_bytes_next[55:0], b};
        end

        if (capture_en)
        begin
            byte_count_next = byte_count_reg + 1'b1;
        end
        else
        begin
            byte_count_next = byte_count_reg;
        end
        len_ext = EXT_W'(byte_count_next);

        icmp_match = ether_type_next == ETHERTYPE_IPV4
                     && len_ext >= EXT_W'(ETH_HDR_LEN + IPV4_MIN_HDR)
                     && ip_protocol_next == PROTO_NUM_ICMP
                     && len_ext >= icmp_start + EXT_W'(ICMP_LEN);

        rec_next = '0;
        if (len_ext > EXT_W'(FRAME_LEN_MAX))
        begin
            rec_next.frame_len = 11'(FRAME_LEN_MAX);
        end
        else
        begin
            rec_next.frame_len = len_ext[10:0];
        end
        rec_next.dst_mac = dst_mac_next;
        rec_next.src_mac = src_mac_next;
        rec_next.ether_type = ether_type_next;
        rec_next.is_icmp = icmp_match;
        if (icmp_match)
        begin
            rec_next.msg_type = icmp_bytes_next[63:56];
            rec_next.msg_code = icmp_bytes_next[55:48];
            rec_next.icmp_ident = icmp_bytes_next[31:16];
            rec_next.icmp_sequence = icmp_bytes_next[15:0];
            rec_next.ip_source = ip_addresses_next[63:32];
            rec_next.ip_destination = ip_addresses_next[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= '0;
            dst_mac_reg <= '0;
            src_mac_reg <= '0;
            ether_type_reg <= '0;
            ip_header_len_reg <= '0;
            ip_protocol_reg <= '0;
            ip_addresses_reg <= '0;
            icmp_bytes_reg <= '0;
        end
        else if (adv)
        begin
            byte_count_reg <= item.last_byte ? '0 : byte_count_next;
            dst_mac_reg <= dst_mac_next;
            src_mac_reg <= src_mac_next;
            ether_type_reg <= ether_type_next;
            ip_header_len_reg <= ip_header_len_next;
            ip_protocol_reg <= ip_protocol_next;
            ip_addresses_reg <= ip_addresses_next;
            icmp_bytes_reg <= icmp_bytes_next;
        end
    end

`ifndef SYNTHESIS
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        rec_load |=> byte_count_reg == '0)
        else $error("byte count not cleared after the last byte");

    a_zero_unless_icmp: assert property (@(posedge clk) disable iff (!rst_n)
        rec_load && !rec_next.is_icmp |->
            rec_next.ip_source == '0 && rec_next.ip_destination == '0
            && rec_next.msg_type == '0 && rec_next.icmp_ident == '0)
        else $error("ICMP fields nonzero on a non-ICMP frame");

    a_icmp_len: assert property (@(posedge clk) disable iff (!rst_n)
        rec_load && rec_next.is_icmp |->
            rec_next.frame_len >= 11'(ETH_HDR_LEN + IPV4_MIN_HDR)
            && rec_next.ether_type == ETHERTYPE_IPV4)
        else $error("ICMP record on a short or non-IPv4 frame");
`endif

endmodule

### rtl/core/ihe_out_stage.sv
// Result register that holds one frame record until the receiver takes it.
module ihe_out_stage
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 rec_load,
    input  ihe_pkg::ihe_record_t rec_next,
    input  logic                 out_stall,
    output logic                 out_valid,
    output logic                 out_free,
    output ihe_pkg::ihe_record_t rec
);
    import ihe_pkg::*;

    logic        out_valid_reg;
    ihe_record_t rec_reg;

    assign out_valid = out_valid_reg;
    assign out_free = !out_valid_reg || !out_stall;
    assign rec = rec_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (rec_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rec_load)
        begin
            rec_reg <= rec_next;
        end
    end

endmodule
